[rtl/bmc_pkg.sv]
// Shared types and constants for the BGP message classifier.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package bmc_pkg;

  // Width of the running counters; the ports show the low 32 bits.
  localparam int unsigned CountBits = 32;

  // Header byte offsets
  localparam logic [15:0] PosLenHi   = 16'd16;
  localparam logic [15:0] PosLenLo   = 16'd17;
  localparam logic [15:0] PosType    = 16'd18;
  localparam logic [15:0] PosWdrLenHi = 16'd19;
  localparam logic [15:0] PosWdrLenLo = 16'd20;
  localparam logic [16:0] AttrLenHiBase = 17'd21;
  localparam logic [16:0] AttrLenLoBase = 17'd22;
  localparam logic [17:0] SectionBase   = 18'd23;

  // Minimum lengths
  localparam logic [16:0] ShortLimit = 17'd18;
  localparam logic [16:0] EorLength  = 17'd23;

  // Message type codes
  localparam logic [7:0] TypeOpen      = 8'd1;
  localparam logic [7:0] TypeUpdate    = 8'd2;
  localparam logic [7:0] TypeNotify    = 8'd3;
  localparam logic [7:0] TypeKeepalive = 8'd4;

  // Path attribute type codes and the extended-length flag bit (0x10)
  localparam logic [7:0] AttrMed       = 8'd4;
  localparam logic [7:0] AttrLocalPref = 8'd5;
  localparam int unsigned AttrExtLenBit = 4;

  typedef enum logic [2:0] {
    ClsOpen         = 3'd0,
    ClsPlainUpdate  = 3'd1,
    ClsWithdraw     = 3'd2,
    ClsMpBgp        = 3'd3,
    ClsMixed        = 3'd4,
    ClsEndOfRib     = 3'd5,
    ClsNotification = 3'd6,
    ClsKeepalive    = 3'd7
  } msg_class_e;

  typedef enum logic [2:0] {
    ErrNone        = 3'd0,
    ErrShort       = 3'd1,
    ErrLenMismatch = 3'd2,
    ErrBadType     = 3'd3,
    ErrOverrun     = 3'd4,
    ErrWdrNlri     = 3'd5,
    ErrAttrAlign   = 3'd6,
    ErrMixedNoNlri = 3'd7
  } msg_err_e;

  // Parser state as it stands after the final byte of a message
  typedef struct packed {
    logic [16:0] msg_len;
    logic [15:0] hdr_len;
    logic [7:0]  msg_kind;
    logic [15:0] wdr_len;
    logic [15:0] attr_len;
    logic        attr_aligned;
    logic [15:0] med_cnt;
    logic [15:0] lp_cnt;
  } msg_snap_t;

  // Verdict for one message, handed to the counter stage
  typedef struct packed {
    msg_class_e  cls;
    msg_err_e    err;
    logic        upd_msg;
    logic [15:0] med_cnt;
    logic [15:0] lp_cnt;
  } msg_verdict_t;

endpackage

`default_nettype wire

[rtl/bmc_parser.sv]
// Byte walker: header fields, UPDATE section lengths and attribute walk.
// Holds a snapshot of the message state after its final byte. Uses bmc_pkg.
`default_nettype none

module bmc_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output logic                   snap_valid_o,
  output bmc_pkg::msg_snap_t     snap_o,
  input  wire logic              snap_take_i
);

  typedef enum logic [2:0] {
    PhFlags = 3'd0,
    PhType  = 3'd1,
    PhLenHi = 3'd2,
    PhLenLo = 3'd3,
    PhValue = 3'd4
  } attr_phase_e;

  logic [15:0] pos_q, pos_d;
  logic [15:0] hdr_len_q, hdr_len_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] wdr_len_q, wdr_len_d;
  logic [15:0] attr_len_q, attr_len_d;
  attr_phase_e phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] med_q, med_d;
  logic [15:0] lp_q, lp_d;

  logic              snap_valid_q, snap_valid_d;
  bmc_pkg::msg_snap_t snap_q, snap_d;

  logic        snap_move;
  logic        accept;
  logic [16:0] attr_hi_pos, attr_lo_pos;
  logic [17:0] sect_start, sect_end;
  logic        in_section;
  logic [15:0] rem_dec;
  logic [15:0] rem_join;

  assign snap_move = ~snap_valid_q | snap_take_i;
  // Only a final byte needs the snapshot slot; other beats keep flowing.
  assign stall_o   = last_byte_i & ~snap_move;
  assign accept    = valid_i & ~stall_o;

  assign attr_hi_pos = {1'b0, wdr_len_q} + bmc_pkg::AttrLenHiBase;
  assign attr_lo_pos = {1'b0, wdr_len_q} + bmc_pkg::AttrLenLoBase;
  assign sect_start  = {2'b00, wdr_len_q} + bmc_pkg::SectionBase;
  assign sect_end    = sect_start + {2'b00, attr_len_q};
  assign in_section  = ({2'b00, pos_q} >= sect_start) && ({2'b00, pos_q} < sect_end);
  assign rem_dec     = (rem_q != 16'd0) ? rem_q - 16'd1 : rem_q;
  assign rem_join    = rem_q | {8'h00, data_byte_i};

  always_comb begin
    pos_d      = pos_q;
    hdr_len_d  = hdr_len_q;
    type_d     = type_q;
    wdr_len_d  = wdr_len_q;
    attr_len_d = attr_len_q;
    phase_d    = phase_q;
    flags_d    = flags_q;
    rem_d      = rem_q;
    med_d      = med_q;
    lp_d       = lp_q;

    if (accept) begin
      priority if (pos_q == bmc_pkg::PosLenHi) begin
        hdr_len_d = {data_byte_i, 8'h00};
      end else if (pos_q == bmc_pkg::PosLenLo) begin
        hdr_len_d = hdr_len_q | {8'h00, data_byte_i};
      end else if (pos_q == bmc_pkg::PosType) begin
        type_d = data_byte_i;
      end else if (type_q == bmc_pkg::TypeUpdate) begin
        if (pos_q == bmc_pkg::PosWdrLenHi) begin
          wdr_len_d = {data_byte_i, 8'h00};
        end else if (pos_q == bmc_pkg::PosWdrLenLo) begin
          wdr_len_d = wdr_len_q | {8'h00, data_byte_i};
        end else if ({1'b0, pos_q} == attr_hi_pos) begin
          attr_len_d = {data_byte_i, 8'h00};
        end else if ({1'b0, pos_q} == attr_lo_pos) begin
          attr_len_d = attr_len_q | {8'h00, data_byte_i};
        end else if (in_section) begin
          unique case (phase_q)
            PhFlags: begin
              flags_d = data_byte_i;
              phase_d = PhType;
            end
            PhType: begin
              if (data_byte_i == bmc_pkg::AttrMed) begin
                med_d = med_q + 16'd1;
              end else if (data_byte_i == bmc_pkg::AttrLocalPref) begin
                lp_d = lp_q + 16'd1;
              end
              phase_d = flags_q[bmc_pkg::AttrExtLenBit] ? PhLenHi : PhLenLo;
              rem_d   = 16'd0;
            end
            PhLenHi: begin
              rem_d   = {data_byte_i, 8'h00};
              phase_d = PhLenLo;
            end
            PhLenLo: begin
              rem_d   = rem_join;
              phase_d = (rem_join != 16'd0) ? PhValue : PhFlags;
            end
            PhValue: begin
              rem_d = rem_dec;
              if (rem_dec == 16'd0) begin
                phase_d = PhFlags;
              end
            end
            default: begin
              phase_d = PhFlags;
            end
          endcase
        end
      end else begin
        // body bytes of other message types are not parsed
      end
      if (pos_q != 16'hFFFF) begin
        pos_d = pos_q + 16'd1;
      end
    end

    // Snapshot takes the state including the final byte itself
    snap_d.msg_len      = {1'b0, pos_q} + 17'd1;
    snap_d.hdr_len      = hdr_len_d;
    snap_d.msg_kind     = type_d;
    snap_d.wdr_len      = wdr_len_d;
    snap_d.attr_len     = attr_len_d;
    snap_d.attr_aligned = (phase_d == PhFlags);
    snap_d.med_cnt      = med_d;
    snap_d.lp_cnt       = lp_d;

    if (accept && last_byte_i) begin
      pos_d      = 16'd0;
      hdr_len_d  = 16'd0;
      type_d     = 8'd0;
      wdr_len_d  = 16'd0;
      attr_len_d = 16'd0;
      phase_d    = PhFlags;
      flags_d    = 8'd0;
      rem_d      = 16'd0;
      med_d      = 16'd0;
      lp_d       = 16'd0;
    end

    snap_valid_d = snap_move ? (accept & last_byte_i) : snap_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 16'd0;
      hdr_len_q    <= 16'd0;
      type_q       <= 8'd0;
      wdr_len_q    <= 16'd0;
      attr_len_q   <= 16'd0;
      phase_q      <= PhFlags;
      flags_q      <= 8'd0;
      rem_q        <= 16'd0;
      med_q        <= 16'd0;
      lp_q         <= 16'd0;
      snap_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      hdr_len_q    <= hdr_len_d;
      type_q       <= type_d;
      wdr_len_q    <= wdr_len_d;
      attr_len_q   <= attr_len_d;
      phase_q      <= phase_d;
      flags_q      <= flags_d;
      rem_q        <= rem_d;
      med_q        <= med_d;
      lp_q         <= lp_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

`default_nettype wire

[rtl/bmc_classify.sv]
// Classification stage: checks a message snapshot and registers a verdict.
// Uses bmc_pkg for the snapshot and verdict types and the codes.
`default_nettype none

module bmc_classify (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                snap_valid_i,
  input  wire bmc_pkg::msg_snap_t  snap_i,
  output logic                     snap_take_o,
  output logic                     verdict_valid_o,
  output bmc_pkg::msg_verdict_t    verdict_o,
  input  wire logic                verdict_take_i
);

  logic                  valid_q;
  bmc_pkg::msg_verdict_t verdict_q, verdict_d;
  logic                  move;
  logic [17:0]           len18;
  logic [17:0]           wdr_end;
  logic [17:0]           sect_end;

  assign move        = ~valid_q | verdict_take_i;
  assign snap_take_o = move;

  assign len18    = {1'b0, snap_i.msg_len};
  assign wdr_end  = {2'b00, snap_i.wdr_len} + bmc_pkg::SectionBase;
  assign sect_end = wdr_end + {2'b00, snap_i.attr_len};

  always_comb begin
    verdict_d.cls     = bmc_pkg::ClsOpen;
    verdict_d.err     = bmc_pkg::ErrNone;
    verdict_d.upd_msg = (snap_i.msg_kind == bmc_pkg::TypeUpdate);
    verdict_d.med_cnt = snap_i.med_cnt;
    verdict_d.lp_cnt  = snap_i.lp_cnt;

    priority if (snap_i.msg_len <= bmc_pkg::ShortLimit) begin
      verdict_d.err = bmc_pkg::ErrShort;
    end else if ({1'b0, snap_i.hdr_len} != snap_i.msg_len) begin
      verdict_d.err = bmc_pkg::ErrLenMismatch;
    end else if (snap_i.msg_kind == bmc_pkg::TypeOpen) begin
      verdict_d.cls = bmc_pkg::ClsOpen;
    end else if (snap_i.msg_kind == bmc_pkg::TypeNotify) begin
      verdict_d.cls = bmc_pkg::ClsNotification;
    end else if (snap_i.msg_kind == bmc_pkg::TypeKeepalive) begin
      verdict_d.cls = bmc_pkg::ClsKeepalive;
    end else if (snap_i.msg_kind != bmc_pkg::TypeUpdate) begin
      verdict_d.err = bmc_pkg::ErrBadType;
    end else if (len18 < sect_end) begin
      verdict_d.err = bmc_pkg::ErrOverrun;
    end else if (snap_i.msg_len == bmc_pkg::EorLength) begin
      verdict_d.cls = bmc_pkg::ClsEndOfRib;
    end else if (snap_i.attr_len == 16'd0) begin
      if (len18 != wdr_end) begin
        verdict_d.err = bmc_pkg::ErrWdrNlri;
      end else begin
        verdict_d.cls = bmc_pkg::ClsWithdraw;
      end
    end else if (!snap_i.attr_aligned) begin
      verdict_d.err = bmc_pkg::ErrAttrAlign;
    end else if (snap_i.wdr_len == 16'd0) begin
      // any bytes past the attributes are NLRI
      verdict_d.cls = (len18 != sect_end) ? bmc_pkg::ClsPlainUpdate : bmc_pkg::ClsMpBgp;
    end else if (len18 == sect_end) begin
      verdict_d.err = bmc_pkg::ErrMixedNoNlri;
    end else begin
      verdict_d.cls = bmc_pkg::ClsMixed;
    end

    if (verdict_d.err != bmc_pkg::ErrNone) begin
      verdict_d.cls = bmc_pkg::ClsOpen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (move) begin
      valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && snap_valid_i) begin
      verdict_q <= verdict_d;
    end
  end

  assign verdict_valid_o = valid_q;
  assign verdict_o       = verdict_q;

endmodule

`default_nettype wire

[rtl/bmc_counters.sv]
// Counter and output stage: per-class and grand totals, result register.
// Uses bmc_pkg for the verdict type, codes and counter width.
`default_nettype none

module bmc_counters (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   verdict_valid_i,
  input  wire bmc_pkg::msg_verdict_t  verdict_i,
  output logic                        verdict_take_o,
  output logic                        valid_o,
  input  wire logic                   stall_i,
  output logic [2:0]                  message_class_o,
  output logic                        plain_update_o,
  output logic [2:0]                  error_code_o,
  output logic [31:0]                 class_total_o,
  output logic [31:0]                 message_total_o,
  output logic [31:0]                 med_total_o,
  output logic [31:0]                 local_pref_total_o
);

  localparam int unsigned CW = bmc_pkg::CountBits;

  logic [CW-1:0] class_cnt_q [8];
  logic [CW-1:0] msg_cnt_q, med_cnt_q, lp_cnt_q;
  logic [CW-1:0] class_inc, msg_inc, med_sum, lp_sum;

  logic          valid_q;
  logic          move;
  logic          load;
  logic          ok;

  logic [2:0]    cls_q;
  logic          plain_q;
  logic [2:0]    err_q;
  logic [31:0]   class_tot_q, msg_tot_q, med_tot_q, lp_tot_q;

  assign move           = ~valid_q | ~stall_i;
  assign verdict_take_o = move;
  assign load           = move & verdict_valid_i;
  assign ok             = (verdict_i.err == bmc_pkg::ErrNone);

  assign class_inc = class_cnt_q[verdict_i.cls] + CW'(1);
  assign msg_inc   = msg_cnt_q + CW'(1);
  assign med_sum   = verdict_i.upd_msg ? med_cnt_q + CW'(verdict_i.med_cnt) : med_cnt_q;
  assign lp_sum    = verdict_i.upd_msg ? lp_cnt_q + CW'(verdict_i.lp_cnt) : lp_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      msg_cnt_q <= '0;
      med_cnt_q <= '0;
      lp_cnt_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        class_cnt_q[i] <= '0;
      end
    end else begin
      if (move) begin
        valid_q <= verdict_valid_i;
      end
      // a failed message counts nothing, its attributes included
      if (load && ok) begin
        class_cnt_q[verdict_i.cls] <= class_inc;
        msg_cnt_q                  <= msg_inc;
        med_cnt_q                  <= med_sum;
        lp_cnt_q                   <= lp_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q   <= verdict_i.cls;
      err_q   <= verdict_i.err;
      plain_q <= ok && (verdict_i.cls == bmc_pkg::ClsPlainUpdate);
      if (ok) begin
        class_tot_q <= 32'(class_inc);
        msg_tot_q   <= 32'(msg_inc);
        med_tot_q   <= 32'(med_sum);
        lp_tot_q    <= 32'(lp_sum);
      end else begin
        class_tot_q <= 32'd0;
        msg_tot_q   <= 32'(msg_cnt_q);
        med_tot_q   <= 32'(med_cnt_q);
        lp_tot_q    <= 32'(lp_cnt_q);
      end
    end
  end

  assign valid_o            = valid_q;
  assign message_class_o    = cls_q;
  assign plain_update_o     = plain_q;
  assign error_code_o       = err_q;
  assign class_total_o      = class_tot_q;
  assign message_total_o    = msg_tot_q;
  assign med_total_o        = med_tot_q;
  assign local_pref_total_o = lp_tot_q;

endmodule

`default_nettype wire

[rtl/bgp_message_classifier_top.sv]
// BGP-4 message classifier, top level.
// Instantiates bmc_parser, bmc_classify and bmc_counters; uses bmc_pkg.
//
// Input channel: one message byte per beat (data_byte_i, last_byte_i), from
// marker byte zero, last_byte_i set on the final byte. One beat is taken per
// cycle while in_stall_o is low. Output channel: one result beat per message,
// with the class, the plain-update flag, an error code and the running totals.
// The result passes the snapshot, classify and counter registers in turn after
// the final byte is taken. Throughput is one byte per cycle while the receiver
// does not stall; back-to-back messages, even one byte long, keep that rate.
// When the receiver stalls, the result is held and up to two more results
// queue in the classify and snapshot registers; non-final bytes are still
// taken, and only a final byte is stalled once all three are occupied.
// Reset zeroes the parser state, pipeline valid flags and all counters.
// Counters wrap; the total ports show their low 32 bits.
`default_nettype none

module bgp_message_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       message_class_o,
  output logic             plain_update_o,
  output logic [2:0]       error_code_o,
  output logic [31:0]      class_total_o,
  output logic [31:0]      message_total_o,
  output logic [31:0]      med_total_o,
  output logic [31:0]      local_pref_total_o
);

  logic                  snap_valid;
  bmc_pkg::msg_snap_t    snap;
  logic                  snap_take;
  logic                  verdict_valid;
  bmc_pkg::msg_verdict_t verdict;
  logic                  verdict_take;

  bmc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .stall_o      (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_take_i  (snap_take)
  );

  bmc_classify u_classify (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_valid_i    (snap_valid),
    .snap_i          (snap),
    .snap_take_o     (snap_take),
    .verdict_valid_o (verdict_valid),
    .verdict_o       (verdict),
    .verdict_take_i  (verdict_take)
  );

  bmc_counters u_counters (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .verdict_valid_i    (verdict_valid),
    .verdict_i          (verdict),
    .verdict_take_o     (verdict_take),
    .valid_o            (out_valid_o),
    .stall_i            (out_stall_i),
    .message_class_o    (message_class_o),
    .plain_update_o     (plain_update_o),
    .error_code_o       (error_code_o),
    .class_total_o      (class_total_o),
    .message_total_o    (message_total_o),
    .med_total_o        (med_total_o),
    .local_pref_total_o (local_pref_total_o)
  );

endmodule

`default_nettype wire
